### rtl/cds_pkg.sv
// shared constants and types for the 4:4:4 to 4:2:0 chroma box downsampler
// no dependencies; used by the stream interfaces and the top level
package cds_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int IO_BITS     = 16;
    localparam int WIDTH_BITS  = 13;
    localparam int HEIGHT_BITS = 16;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

### rtl/cds_stream_if.sv
// valid/ready stream interfaces for full-resolution input and half-resolution output words
// depends on cds_pkg
interface cds_in_if import cds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IO_BITS-1:0] in_u;
    logic [IO_BITS-1:0] in_v;

    modport source (output valid, output in_u, output in_v, input ready);
    modport sink   (input valid, input in_u, input in_v, output ready);
endinterface

interface cds_out_if import cds_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IO_BITS-1:0] out_u;
    logic [IO_BITS-1:0] out_v;
    logic               last_in_row;
    logic               last_in_frame;

    modport source (output valid, output out_u, output out_v, output last_in_row,
                    output last_in_frame, input ready);
    modport sink   (input valid, input out_u, input out_v, input last_in_row,
                    input last_in_frame, output ready);
endinterface

### rtl/chroma_downsample_444_to_420_box.sv
// top level of the 4:4:4 to 4:2:0 chroma 2x2 box downsampler with apb register port
// depends on cds_pkg and the stream interfaces in cds_stream_if.sv
// a result word is registered in stage 1, then in the output register, before o_pix.valid rises
// throughput: one input word per cycle unless stalled; the line buffer is read or written once per cycle
// reset: synchronous active low; clears positions, pair sums and valids, width and height to 1
// the line buffer is not cleared; rows are written before they are read
module chroma_downsample_444_to_420_box import cds_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cds_in_if.sink                i_pix,
    cds_out_if.source             o_pix,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int CW         = ($clog2(MAX_WIDTH) > 0) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW         = ($clog2(LINE_DEPTH) > 0) ? $clog2(LINE_DEPTH) : 1;
    localparam int EW         = ($clog2(MAX_WIDTH + 1) > WIDTH_BITS) ?
                                $clog2(MAX_WIDTH + 1) : WIDTH_BITS;
    localparam int PW         = SAMPLE_BITS + 1;
    localparam int SW         = SAMPLE_BITS + 3;

    // configuration
    logic [WIDTH_BITS-1:0]  r_width;
    logic [HEIGHT_BITS-1:0] r_height;
    logic                   cfg_wr;
    t_cfg_reg               cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = t_cfg_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_BITS'(1);
            r_height <= HEIGHT_BITS'(1);
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[HEIGHT_BITS-1:0];
                default:          r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    // position and pair tracking
    logic [CW-1:0]          r_col;
    logic [HEIGHT_BITS-1:0] r_row;
    logic [PW-1:0]          r_pend_u;
    logic [PW-1:0]          r_pend_v;

    logic [EW-1:0]          w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic                   last_col;
    logic                   last_row;
    logic                   pair_done;
    logic                   top_write;
    logic                   emit;
    logic                   vadd;
    logic [PW-1:0]          n_pend_u;
    logic [PW-1:0]          n_pend_v;
    logic [CW-1:0]          n_col;
    logic [HEIGHT_BITS-1:0] n_row;
    logic [CW-1:0]          col_half;
    logic [AW-1:0]          line_addr;
    logic [SAMPLE_BITS-1:0] s_u;
    logic [SAMPLE_BITS-1:0] s_v;
    logic                   accept;

    // stage 1 and output registers
    logic                   r_s1_valid;
    logic                   r_s1_vadd;
    logic                   r_s1_hshift;
    logic                   r_s1_last_col;
    logic                   r_s1_last_row;
    logic [PW-1:0]          r_s1_sum_u;
    logic [PW-1:0]          r_s1_sum_v;
    logic [2*PW-1:0]        r_rd;
    logic                   s1_go;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_u;
    logic [SAMPLE_BITS-1:0] r_out_v;
    logic                   r_out_last_row;
    logic                   r_out_last_frame;

    logic [2*PW-1:0]        r_line_mem [LINE_DEPTH];

    assign s1_go         = r_s1_valid && (!r_out_valid || o_pix.ready);
    assign i_pix.ready   = !r_s1_valid || !r_out_valid || o_pix.ready;
    assign accept        = i_pix.valid && i_pix.ready;

    assign s_u = i_pix.in_u[SAMPLE_BITS-1:0];
    assign s_v = i_pix.in_v[SAMPLE_BITS-1:0];

    always_comb begin
        if (r_width == '0) begin
            w_eff = EW'(1);
        end else if (EW'(r_width) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_width);
        end
        h_eff = (r_height == '0) ? HEIGHT_BITS'(1) : r_height;
    end

    assign last_col  = ((EW + 1)'(r_col) + (EW + 1)'(1)) >= (EW + 1)'(w_eff);
    assign last_row  = ((HEIGHT_BITS + 1)'(r_row) + (HEIGHT_BITS + 1)'(1)) >=
                       (HEIGHT_BITS + 1)'(h_eff);
    assign pair_done = r_col[0] || last_col;
    assign top_write = pair_done && !r_row[0] && !last_row;
    assign emit      = pair_done && (r_row[0] || last_row);
    assign vadd      = r_row[0];
    assign col_half  = r_col >> 1;
    assign line_addr = col_half[AW-1:0];

    always_comb begin
        if (r_col[0]) begin
            n_pend_u = r_pend_u + PW'(s_u);
            n_pend_v = r_pend_v + PW'(s_v);
        end else begin
            n_pend_u = PW'(s_u);
            n_pend_v = PW'(s_v);
        end
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + HEIGHT_BITS'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_pend_u <= '0;
            r_pend_v <= '0;
        end else if (accept) begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_pend_u <= n_pend_u;
            r_pend_v <= n_pend_v;
        end
    end

    // top-row pair sums
    always_ff @(posedge i_clk) begin
        if (accept && top_write) begin
            r_line_mem[line_addr] <= {n_pend_u, n_pend_v};
        end
        if (accept && emit && vadd) begin
            r_rd <= r_line_mem[line_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= emit;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_vadd     <= vadd;
            r_s1_hshift   <= r_col[0];
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
            r_s1_sum_u    <= n_pend_u;
            r_s1_sum_v    <= n_pend_v;
        end
    end

    // rounded average of up to four samples
    function automatic logic [SAMPLE_BITS-1:0] box_avg(
        input logic [PW-1:0] pend,
        input logic [PW-1:0] top,
        input logic          add_top,
        input logic          hshift
    );
        logic [SW-1:0] sum;
        logic [1:0]    sh;
        logic [SW-1:0] rounded;
        sum = SW'(pend) + (add_top ? SW'(top) : SW'(0));
        sh  = 2'(hshift) + 2'(add_top);
        unique case (sh)
            2'd0:    rounded = sum;
            2'd1:    rounded = (sum + SW'(1)) >> 1;
            2'd2:    rounded = (sum + SW'(2)) >> 2;
            default: rounded = sum;
        endcase
        return rounded[SAMPLE_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_u          <= box_avg(r_s1_sum_u, r_rd[2*PW-1:PW], r_s1_vadd, r_s1_hshift);
            r_out_v          <= box_avg(r_s1_sum_v, r_rd[PW-1:0], r_s1_vadd, r_s1_hshift);
            r_out_last_row   <= r_s1_last_col;
            r_out_last_frame <= r_s1_last_col && r_s1_last_row;
        end
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.out_u         = IO_BITS'(r_out_u);
    assign o_pix.out_v         = IO_BITS'(r_out_v);
    assign o_pix.last_in_row   = r_out_last_row;
    assign o_pix.last_in_frame = r_out_last_frame;

endmodule
